### src/lmpc_pkg.sv
// Shared types, constants and helper functions of the LED mode PWM controller.
`default_nettype none

package lmpc_pkg;

  // Elapsed-tick counter width and encoder counter width.
  localparam int TIMER_BITS   = 16;
  localparam int ENCODER_BITS = 16;

  localparam int CFG_W   = 16;
  localparam int DUTY_W  = 10;
  localparam int ENC_W   = 16;
  localparam int DIGIT_W = 8;
  localparam int CMP_W   = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  // Mask applied to the incoming encoder count, and half of the counter range.
  localparam logic [ENC_W-1:0] ENC_IN_MASK =
    (ENCODER_BITS >= ENC_W) ? {ENC_W{1'b1}} : ENC_W'((64'd1 << ENCODER_BITS) - 64'd1);
  localparam logic [32:0] ENC_HALF = 33'd1 << (ENCODER_BITS - 1);

  // Configuration register indexes.
  localparam logic [2:0] CFG_DEBOUNCE_TICKS    = 3'd0;
  localparam logic [2:0] CFG_BLINK_HALF_PERIOD = 3'd1;
  localparam logic [2:0] CFG_BREATH_INTERVAL   = 3'd2;
  localparam logic [2:0] CFG_BREATH_STEP       = 3'd3;
  localparam logic [2:0] CFG_DUTY_FULL         = 3'd4;

  // Command kinds, also used as reply kinds.
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_TEMP = 2'd1;
  localparam logic [1:0] CMD_SAVE = 2'd2;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 8'd4;

  typedef enum logic [2:0] {
    MODE_ON      = 3'd0,
    MODE_OFF     = 3'd1,
    MODE_BLINK   = 3'd2,
    MODE_BREATH  = 3'd3,
    MODE_ENCODER = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_WAIT     = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CFG_W-1:0]  debounce_ticks;
    logic [CFG_W-1:0]  blink_half_period;
    logic [CFG_W-1:0]  breath_interval;
    logic [DUTY_W-1:0] breath_step;
    logic [DUTY_W-1:0] duty_full;
  } cfg_t;

  // Result of the button step handed to the duty logic.
  typedef struct packed {
    phase_e                phase;
    logic [TIMER_BITS-1:0] elapsed;
    mode_e                 mode;
    logic                  enter_enc;
  } btn_t;

  // Result of the mode behavior step.
  typedef struct packed {
    logic [DUTY_W-1:0]     duty;
    logic [TIMER_BITS-1:0] blink_elapsed;
    logic [TIMER_BITS-1:0] breath_elapsed;
    logic                  rising;
    logic                  clamp_load;
    logic [DUTY_W-1:0]     clamp_val;
  } duty_t;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (v == {TIMER_BITS{1'b1}}) ? v : v + TIMER_BITS'(1);
  endfunction

  function automatic logic timer_reached(input logic [TIMER_BITS-1:0] t,
                                         input logic [CFG_W-1:0] lim);
    return CMP_W'(t) >= CMP_W'(lim);
  endfunction

endpackage

`default_nettype wire

### src/led_mode_pwm_controller_top.sv
// Top level of the LED mode PWM controller: tick state, command step and result register.
`default_nettype none

// Channel   Direction  Signals                          Contents
// s_axis    in         tvalid tready tdata[31:0] tuser  one millisecond tick with button,
//                                                       encoder count and parsed command
// m_axis    out        tvalid tready tdata[23:0] tuser  duty, mode, encoder load, reply
// cfg       in         cfg_we_i cfg_index_i cfg_wdata_i register writes, no read-back
//
// Each tick transaction is handled by a short combinational pass: the debounce, mode and
// command steps run from the state registers to the result register.
// Without a stall, one tick is accepted per cycle; the result follows in the cycle after.
// While a result is stalled, a new tick is taken in the same cycle the result is taken.
// Reset restores the default configuration, idles the debounce machine, selects the
// always-on mode and clears the duty and all elapsed counters.

module led_mode_pwm_controller_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  // Tick input.
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [0] button_level, [16:1] encoder_count, [24:17] cmd_digit, [31:25] zero
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] cmd_kind
  input  wire logic [1:0]  s_axis_tuser,
  // Result output.
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [9:0] duty, [12:10] mode, [13] encoder_load, [23:14] encoder_value
  output      logic [23:0] m_axis_tdata,
  // [1:0] reply_kind
  output      logic [1:0]  m_axis_tuser
);
  import lmpc_pkg::*;

  cfg_t cfg;

  // Tick state.
  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] press_elapsed_q, press_elapsed_d;
  mode_e                 mode_q, mode_d;
  logic [DUTY_W-1:0]     duty_q, duty_d;
  logic [TIMER_BITS-1:0] blink_elapsed_q, blink_elapsed_d;
  logic [TIMER_BITS-1:0] breath_elapsed_q, breath_elapsed_d;
  logic                  rising_q, rising_d;

  // Result register.
  logic        out_valid_q;
  logic [23:0] out_data_q, out_data_d;
  logic [1:0]  out_user_q, out_user_d;

  logic                 in_accept;
  logic                 pressed;
  logic [ENC_W-1:0]     encoder_count;
  logic [DIGIT_W-1:0]   cmd_digit;
  logic [1:0]           cmd_kind;
  logic                 cmd_ok;
  logic                 load;
  logic [DUTY_W-1:0]    load_val;
  btn_t                 btn;
  duty_t                dty;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign pressed       = !s_axis_tdata[0];
  assign encoder_count = s_axis_tdata[16:1];
  assign cmd_digit     = s_axis_tdata[24:17];
  assign cmd_kind      = s_axis_tuser;

  lmpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lmpc_debounce u_debounce (
    .pressed_i        (pressed),
    .phase_i          (phase_q),
    .elapsed_i        (press_elapsed_q),
    .mode_i           (mode_q),
    .debounce_ticks_i (cfg.debounce_ticks),
    .btn_o            (btn)
  );

  lmpc_duty u_duty (
    .mode_i           (btn.mode),
    .duty_i           (duty_q),
    .blink_elapsed_i  (blink_elapsed_q),
    .breath_elapsed_i (breath_elapsed_q),
    .rising_i         (rising_q),
    .enter_enc_i      (btn.enter_enc),
    .encoder_count_i  (encoder_count),
    .cfg_i            (cfg),
    .duty_o           (dty)
  );

  // A command with a digit above four, or an unused kind, is dropped without a reply.
  assign cmd_ok = ((cmd_kind == CMD_TEMP) || (cmd_kind == CMD_SAVE)) && (cmd_digit <= DIGIT_MAX);

  always_comb begin
    phase_d          = btn.phase;
    press_elapsed_d  = btn.elapsed;
    duty_d           = dty.duty;
    blink_elapsed_d  = dty.blink_elapsed;
    breath_elapsed_d = dty.breath_elapsed;
    rising_d         = dty.rising;
    mode_d           = btn.mode;
    out_user_d       = CMD_NONE;

    // The last encoder write of the tick wins, so command beats clamp and clamp beats button.
    load     = btn.enter_enc || dty.clamp_load;
    load_val = dty.clamp_load ? dty.clamp_val : duty_q;

    if (cmd_ok) begin
      mode_d     = mode_e'(cmd_digit[2:0]);
      out_user_d = cmd_kind;
      if (mode_d == MODE_ENCODER) begin
        load     = 1'b1;
        load_val = dty.duty;
      end
    end

    out_data_d = {(load ? load_val : {DUTY_W{1'b0}}), load, mode_d, duty_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_IDLE;
      press_elapsed_q  <= '0;
      mode_q           <= MODE_ON;
      duty_q           <= '0;
      blink_elapsed_q  <= '0;
      breath_elapsed_q <= '0;
      rising_q         <= 1'b1;
      out_valid_q      <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_q          <= phase_d;
        press_elapsed_q  <= press_elapsed_d;
        mode_q           <= mode_d;
        duty_q           <= duty_d;
        blink_elapsed_q  <= blink_elapsed_d;
        breath_elapsed_q <= breath_elapsed_d;
        rising_q         <= rising_d;
        out_valid_q      <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // The mode reported in a result is always one of the five modes.
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[12:10] <= 3'd4))
    else $error("result mode out of range");

  // Without an encoder load the reported load value is zero.
  a_load_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[13]) |-> (m_axis_tdata[23:14] == '0))
    else $error("encoder value without load");

  // An accepted command with a valid digit sets the mode and is acknowledged.
  a_cmd_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && cmd_ok) |=>
      (m_axis_tvalid && (m_axis_tdata[12:10] == $past(cmd_digit[2:0]))
       && (m_axis_tuser == $past(cmd_kind))))
    else $error("command not applied");

  // The mode register follows the result register after every tick.
  a_mode_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_accept) |-> (mode_q == mode_e'(m_axis_tdata[12:10])))
    else $error("mode state and result disagree");

endmodule

`default_nettype wire

### src/lmpc_cfg_regs.sv
// Configuration register bank of the LED mode PWM controller.
`default_nettype none

module lmpc_cfg_regs (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_index_i,
  input  wire logic [15:0]          cfg_wdata_i,
  output      lmpc_pkg::cfg_t       cfg_o
);
  import lmpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE_TICKS:    cfg_d.debounce_ticks    = cfg_wdata_i;
        CFG_BLINK_HALF_PERIOD: cfg_d.blink_half_period = cfg_wdata_i;
        CFG_BREATH_INTERVAL:   cfg_d.breath_interval   = cfg_wdata_i;
        CFG_BREATH_STEP:       cfg_d.breath_step       = cfg_wdata_i[DUTY_W-1:0];
        CFG_DUTY_FULL:         cfg_d.duty_full         = cfg_wdata_i[DUTY_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks    <= 16'd20;
      cfg_q.blink_half_period <= 16'd500;
      cfg_q.breath_interval   <= 16'd15;
      cfg_q.breath_step       <= 10'd10;
      cfg_q.duty_full         <= 10'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### src/lmpc_debounce.sv
// Button debounce step: press phase, press timer and cyclic mode advance.
`default_nettype none

module lmpc_debounce (
  input  wire logic                               pressed_i,
  input  wire lmpc_pkg::phase_e                   phase_i,
  input  wire logic [lmpc_pkg::TIMER_BITS-1:0]    elapsed_i,
  input  wire lmpc_pkg::mode_e                    mode_i,
  input  wire logic [lmpc_pkg::CFG_W-1:0]         debounce_ticks_i,
  output      lmpc_pkg::btn_t                     btn_o
);
  import lmpc_pkg::*;

  logic [TIMER_BITS-1:0] elapsed_inc;
  mode_e                 mode_next;

  assign elapsed_inc = sat_inc(elapsed_i);

  always_comb begin
    unique case (mode_i)
      MODE_ON:     mode_next = MODE_OFF;
      MODE_OFF:    mode_next = MODE_BLINK;
      MODE_BLINK:  mode_next = MODE_BREATH;
      MODE_BREATH: mode_next = MODE_ENCODER;
      default:     mode_next = MODE_ON;
    endcase
  end

  always_comb begin
    btn_o.phase     = phase_i;
    btn_o.elapsed   = elapsed_inc;
    btn_o.mode      = mode_i;
    btn_o.enter_enc = 1'b0;
    unique case (phase_i)
      PH_DEBOUNCE: begin
        if (timer_reached(elapsed_inc, debounce_ticks_i)) begin
          if (pressed_i) begin
            btn_o.mode      = mode_next;
            btn_o.enter_enc = (mode_next == MODE_ENCODER);
            btn_o.phase     = PH_WAIT;
          end else begin
            btn_o.phase = PH_IDLE;
          end
        end
      end
      PH_WAIT: begin
        if (!pressed_i) btn_o.phase = PH_IDLE;
      end
      default: begin
        // Idle, and the unused phase code which falls back to idle.
        btn_o.phase = PH_IDLE;
        if (pressed_i) begin
          btn_o.phase   = PH_DEBOUNCE;
          btn_o.elapsed = '0;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### src/lmpc_duty.sv
// Mode behavior step: derives the PWM duty from the current mode.
`default_nettype none

module lmpc_duty (
  input  wire lmpc_pkg::mode_e                    mode_i,
  input  wire logic [lmpc_pkg::DUTY_W-1:0]        duty_i,
  input  wire logic [lmpc_pkg::TIMER_BITS-1:0]    blink_elapsed_i,
  input  wire logic [lmpc_pkg::TIMER_BITS-1:0]    breath_elapsed_i,
  input  wire logic                               rising_i,
  input  wire logic                               enter_enc_i,
  input  wire logic [lmpc_pkg::ENC_W-1:0]         encoder_count_i,
  input  wire lmpc_pkg::cfg_t                     cfg_i,
  output      lmpc_pkg::duty_t                    duty_o
);
  import lmpc_pkg::*;

  logic [TIMER_BITS-1:0] blink_inc, breath_inc;
  logic [DUTY_W:0]       breath_sum;
  logic [ENC_W-1:0]      enc_val;

  assign blink_inc  = sat_inc(blink_elapsed_i);
  assign breath_inc = sat_inc(breath_elapsed_i);
  assign breath_sum = {1'b0, duty_i} + {1'b0, cfg_i.breath_step};
  // A load made by the button earlier in the tick replaces the sampled count.
  assign enc_val    = enter_enc_i ? ENC_W'(duty_i) : (encoder_count_i & ENC_IN_MASK);

  always_comb begin
    duty_o.duty           = duty_i;
    duty_o.blink_elapsed  = blink_inc;
    duty_o.breath_elapsed = breath_inc;
    duty_o.rising         = rising_i;
    duty_o.clamp_load     = 1'b0;
    duty_o.clamp_val      = '0;
    unique case (mode_i)
      MODE_ON:  duty_o.duty = cfg_i.duty_full;
      MODE_OFF: duty_o.duty = '0;
      MODE_BLINK: begin
        if (timer_reached(blink_inc, cfg_i.blink_half_period)) begin
          duty_o.blink_elapsed = '0;
          duty_o.duty = (duty_i == '0) ? cfg_i.duty_full : '0;
        end
      end
      MODE_BREATH: begin
        if (timer_reached(breath_inc, cfg_i.breath_interval)) begin
          duty_o.breath_elapsed = '0;
          if (rising_i) begin
            if (breath_sum >= {1'b0, cfg_i.duty_full}) begin
              duty_o.duty   = cfg_i.duty_full;
              duty_o.rising = 1'b0;
            end else begin
              duty_o.duty = breath_sum[DUTY_W-1:0];
            end
          end else if (duty_i <= cfg_i.breath_step) begin
            duty_o.duty   = '0;
            duty_o.rising = 1'b1;
          end else begin
            duty_o.duty = duty_i - cfg_i.breath_step;
          end
        end
      end
      default: begin
        if (enc_val > ENC_W'(cfg_i.duty_full)) begin
          duty_o.clamp_load = 1'b1;
          duty_o.clamp_val  = (33'(enc_val) > ENC_HALF) ? '0 : cfg_i.duty_full;
          duty_o.duty       = duty_o.clamp_val;
        end else begin
          duty_o.duty = enc_val[DUTY_W-1:0];
        end
      end
    endcase
  end

endmodule

`default_nettype wire
